>>> rtl/pli_pkg.sv
// pli_pkg: shared types and constants for the positional list insert block
// beat structs, status codes, controller states; no dependencies
`timescale 1ns / 1ps

package pli_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;

    localparam logic [1:0] ST_ENTRY   = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0]         insert_position;
        logic signed [DATA_W-1:0] new_value;
    } pli_in_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     direction;
        logic signed [DATA_W-1:0] entry_value;
        logic                     last_of_run;
    } pli_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_LIST
    } pli_state_t;

endpackage

>>> rtl/pli_ram.sv
// pli_ram: generic single-write, single-read memory with registered read
// no dependencies
`timescale 1ns / 1ps

module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/pli_out_buf.sv
// pli_out_buf: two-beat output register with skid slot
// depends on pli_pkg for the result beat struct
`timescale 1ns / 1ps

module pli_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pli_pkg::pli_out_t push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pli_pkg::pli_out_t out_data,
    output logic [1:0]        fill
);

    logic [1:0]        cnt_reg, cnt_next;
    pli_pkg::pli_out_t slot0_reg, slot0_next;
    pli_pkg::pli_out_t slot1_reg, slot1_next;
    logic              pop;
    logic [1:0]        wpos;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign fill      = cnt_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        wpos       = cnt_reg - {1'b0, pop};
        cnt_next   = cnt_reg + {1'b0, push} - {1'b0, pop};
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        if (push)
        begin
            if (wpos == 2'd0)
            begin
                slot0_next = push_data;
            end
            else
            begin
                slot1_next = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

>>> rtl/positional_list_insert.sv
// positional_list_insert: top level, sequencer around the list memory
// depends on pli_pkg, pli_ram and pli_out_buf
`timescale 1ns / 1ps

// usage
//   input channel in_valid/in_ready/in_data carries one insert request per beat
//   (position and signed value); output channel out_valid/out_ready/out_data
//   carries result beats (status, direction, entry value, last-of-run flag)
//   a bad position or a full list gives one error beat, registered into the
//   output buffer as the request is taken, and leaves the list untouched
//   a good insert first moves the entries from the position to the tail one
//   place up, one entry per cycle through the single memory port pair,
//   writes the new value, then lists the n entries head to tail and tail to
//   head: 2n beats, one per cycle while the receiver keeps up, the first beat
//   following the new-value write through a listing read and the output buffer
//   a new request is taken only once the previous run's last read has reached
//   the output buffer and that buffer has a free slot
//   reset empties the list (count to zero) and drops any pending beats; the
//   memory contents themselves are not cleared, only entries below the count
//   are ever read
//   a stalled receiver holds the output beat steady; reads are issued only
//   while the two-beat output buffer has room, so nothing is lost
module positional_list_insert #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pli_pkg::pli_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pli_pkg::pli_out_t out_data
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // sequencer state
    pli_pkg::pli_state_t        state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           pos_reg, pos_next;
    logic [pli_pkg::DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic                       dir_reg, dir_next;

    // shift pipeline: a read issued last cycle is written one place up now
    logic                       shpend_reg, shpend_next;
    logic [ADDR_W-1:0]          shaddr_reg, shaddr_next;

    // listing read in flight, with its tags
    logic                       rd_pend_reg, rd_pend_next;
    logic                       rd_dir_reg, rd_dir_next;
    logic                       rd_last_reg, rd_last_next;

    // memory port
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [pli_pkg::DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [pli_pkg::DATA_W-1:0] mem_rdata;

    // output buffer side
    logic                       err_push;
    pli_pkg::pli_out_t          err_beat;
    logic                       push;
    pli_pkg::pli_out_t          push_data;
    logic [1:0]                 buf_fill;
    logic                       pop;
    logic [2:0]                 occ_after;
    logic                       issue_ok;

    logic                       accept;
    logic                       pos_bad;
    logic                       list_full;

    pli_ram #(
        .WIDTH (pli_pkg::DATA_W),
        .DEPTH (CAPACITY),
        .ADDR_W(ADDR_W)
    ) u_list_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    pli_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .fill     (buf_fill)
    );

    // requests only between runs, with no read still in flight and a free output slot
    assign in_ready  = (state_reg == pli_pkg::S_IDLE) && !rd_pend_reg && (buf_fill != 2'd2);
    assign accept    = in_valid && in_ready;
    assign pos_bad   = in_data.insert_position >
                       {{(pli_pkg::POS_W - CNT_W){1'b0}}, count_reg};
    assign list_full = (count_reg == CNT_W'(CAPACITY));

    // buffer occupancy once this cycle's pop is done, counting the read in flight
    assign pop       = out_valid && out_ready;
    assign occ_after = {1'b0, buf_fill} + {2'b00, rd_pend_reg} - {2'b00, pop};
    assign issue_ok  = (occ_after < 3'd2);

    // error beats and listing beats never coincide: errors only when nothing in flight
    assign push = rd_pend_reg || err_push;

    always_comb
    begin
        if (rd_pend_reg)
        begin
            push_data.status      = pli_pkg::ST_ENTRY;
            push_data.direction   = rd_dir_reg;
            push_data.entry_value = mem_rdata;
            push_data.last_of_run = rd_last_reg;
        end
        else
        begin
            push_data = err_beat;
        end
    end

    // address of the entry just below a list index
    function automatic logic [ADDR_W-1:0] idx_next_dec(input logic [CNT_W-1:0] idx);
        logic [CNT_W-1:0] dec;
        dec = idx - CNT_W'(1);
        return dec[ADDR_W-1:0];
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        dir_next     = dir_reg;
        shpend_next  = 1'b0;
        shaddr_next  = shaddr_reg;
        rd_pend_next = 1'b0;
        rd_dir_next  = rd_dir_reg;
        rd_last_next = rd_last_reg;
        mem_we       = 1'b0;
        mem_waddr    = shaddr_reg;
        mem_wdata    = mem_rdata;
        mem_raddr    = idx_reg[ADDR_W-1:0];
        err_push     = 1'b0;
        err_beat.status      = pli_pkg::ST_INVALID;
        err_beat.direction   = 1'b0;
        err_beat.entry_value = '0;
        err_beat.last_of_run = 1'b1;

        case (state_reg)
            pli_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (pos_bad)
                    begin
                        // position check comes first, even on a full list
                        err_push = 1'b1;
                    end
                    else if (list_full)
                    begin
                        err_push        = 1'b1;
                        err_beat.status = pli_pkg::ST_FULL;
                    end
                    else
                    begin
                        pos_next   = in_data.insert_position[CNT_W-1:0];
                        val_next   = in_data.new_value;
                        idx_next   = count_reg;
                        count_next = count_reg + CNT_W'(1);
                        state_next = pli_pkg::S_SHIFT;
                    end
                end
            end

            pli_pkg::S_SHIFT:
            begin
                // finish the move whose read was issued last cycle
                if (shpend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = shaddr_reg;
                    mem_wdata = mem_rdata;
                end
                if (idx_reg != pos_reg)
                begin
                    // read the entry below, move it up next cycle
                    mem_raddr   = idx_next_dec(idx_reg);
                    shaddr_next = idx_reg[ADDR_W-1:0];
                    shpend_next = 1'b1;
                    idx_next    = idx_reg - CNT_W'(1);
                end
                else if (!shpend_reg)
                begin
                    // gap is open: drop the new value in and start listing
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[ADDR_W-1:0];
                    mem_wdata  = val_reg;
                    idx_next   = '0;
                    dir_next   = 1'b0;
                    state_next = pli_pkg::S_LIST;
                end
            end

            pli_pkg::S_LIST:
            begin
                if (issue_ok)
                begin
                    mem_raddr    = idx_reg[ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    rd_dir_next  = dir_reg;
                    rd_last_next = dir_reg && (idx_reg == '0);
                    if (!dir_reg)
                    begin
                        // tail reached: reverse pass starts at the same entry
                        if (idx_reg == count_reg - CNT_W'(1))
                        begin
                            dir_next = 1'b1;
                        end
                        else
                        begin
                            idx_next = idx_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (idx_reg == '0)
                        begin
                            state_next = pli_pkg::S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - CNT_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = pli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pli_pkg::S_IDLE;
            count_reg   <= '0;
            shpend_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            shpend_reg  <= shpend_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        dir_reg     <= dir_next;
        shaddr_reg  <= shaddr_next;
        rd_dir_reg  <= rd_dir_next;
        rd_last_reg <= rd_last_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && (buf_fill == 2'd2) && !pop))
        else $error("push into a full output buffer");

    a_read_from_list: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(state_reg == pli_pkg::S_LIST))
        else $error("listing read without listing state");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CNT_W'(mem_waddr) < count_reg))
        else $error("memory write beyond the list");

    a_no_err_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        err_push |-> !rd_pend_reg && (state_reg == pli_pkg::S_IDLE))
        else $error("error beat mixed into a listing run");
`endif

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for positional_list_insert
// needs pli_pkg and the rtl of the block; predicts every result beat itself
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY    = pli_pkg::CAPACITY_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int IDLE_LIMIT  = 4000;   // cycles with no beat moved on either side
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int HOLD_AFTER  = 40;     // requests taken before the hold-off starts
    localparam int DRAIN_WAIT  = 64;     // wait after the last expected beat, to catch stray beats
    localparam int RANDOM_REQS = 310;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    pli_pkg::pli_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    pli_pkg::pli_out_t out_data;

    positional_list_insert #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // list predictor: own copy of the entries and the fill level
    // ------------------------------------------------------------------
    logic signed [pli_pkg::DATA_W-1:0] list_model [CAPACITY];
    int unsigned                       list_len = 0;
    pli_pkg::pli_out_t                 expected_beats [$];

    int unsigned n_inserts   = 0;
    int unsigned n_bad_pos   = 0;
    int unsigned n_full      = 0;
    int unsigned n_beats_ok  = 0;
    int unsigned n_failures  = 0;
    int unsigned reqs_taken  = 0;

    // works out every beat one request causes and queues them in order
    task automatic predict_insert(input pli_pkg::pli_in_t req);
        pli_pkg::pli_out_t beat;
        int unsigned       pos;
        pos  = 32'(req.insert_position);
        beat = '0;
        if (pos > list_len)
        begin
            // position check wins, even on a full list
            beat.status      = pli_pkg::ST_INVALID;
            beat.last_of_run = 1'b1;
            expected_beats.push_back(beat);
            n_bad_pos++;
        end
        else if (list_len >= CAPACITY)
        begin
            beat.status      = pli_pkg::ST_FULL;
            beat.last_of_run = 1'b1;
            expected_beats.push_back(beat);
            n_full++;
        end
        else
        begin
            // open a gap at pos by moving the tail up one place
            for (int i = list_len; i > pos; i--)
                list_model[i] = list_model[i-1];
            list_model[pos] = req.new_value;
            list_len++;
            n_inserts++;
            beat.status = pli_pkg::ST_ENTRY;
            // forward listing, head to tail
            beat.direction = 1'b0;
            for (int i = 0; i < list_len; i++)
            begin
                beat.entry_value = list_model[i];
                expected_beats.push_back(beat);
            end
            // reverse listing, only the head beat closes the run
            beat.direction = 1'b1;
            for (int i = list_len; i > 0; i--)
            begin
                beat.entry_value = list_model[i-1];
                beat.last_of_run = (i == 1);
                expected_beats.push_back(beat);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // request generation: the generator keeps its own fill level so that
    // positions can be aimed at the head, the tail, the middle or past the end
    // ------------------------------------------------------------------
    pli_pkg::pli_in_t pending_reqs [$];
    int unsigned      gen_len = 0;

    task automatic queue_req(input int unsigned pos,
                             input logic [pli_pkg::DATA_W-1:0] val);
        pli_pkg::pli_in_t req;
        req.insert_position = pos[pli_pkg::POS_W-1:0];
        req.new_value       = val;
        pending_reqs.push_back(req);
        if (pos <= gen_len && gen_len < CAPACITY)
            gen_len++;
    endtask

    function automatic logic [pli_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_pos();
        case ($urandom_range(0, 9))
            0, 1:    return 0;                                   // head
            2, 3:    return gen_len;                             // tail
            4, 5, 6: return $urandom_range(0, gen_len);          // anywhere legal
            7:       return gen_len + 1;                         // one past the end
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    initial
    begin
        // directed: empty list rejects, then inserts at head, tail and middle
        queue_req(1, 32'd5);                  // one past the end of an empty list
        queue_req(255, 32'hffff_ffff);        // largest position
        queue_req(0, 32'h8000_0000);          // first entry, most negative value
        queue_req(1, 32'h7fff_ffff);          // tail, most positive value
        queue_req(0, 32'h0000_0000);          // new head
        queue_req(1, 32'hffff_ffff);          // middle
        queue_req(gen_len + 1, 32'd1);        // just past the tail
        queue_req(gen_len, 32'h5555_5555);    // tail
        queue_req(2, 32'haaaa_aaaa);          // middle
        // fill up with mixed positions
        while (gen_len < CAPACITY)
            queue_req($urandom_range(0, gen_len), pick_value());
        // full list: legal positions give the full status, others stay invalid
        queue_req(0, 32'd7);
        queue_req(CAPACITY, 32'd8);
        queue_req(CAPACITY + 1, 32'd9);
        queue_req(255, 32'h8000_0000);

        // random: the list stays full from here, so mostly legal positions
        // that hit the full check, mixed with positions past the end
        for (int n = 0; n < RANDOM_REQS; n++)
            queue_req(pick_pos(), pick_value());

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all requests handed over, then every predicted beat received
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        // anything the block sends now has no expectation and gets flagged
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_beats.size() != 0)
        begin
            $error("%0d predicted beats never arrived", expected_beats.size());
            n_failures++;
        end
        $display("covered %0d requests: %0d inserts, %0d full rejects, %0d bad positions",
                 reqs_taken, n_inserts, n_full, n_bad_pos);
        $display("%0d result beats matched, %0d failures", n_beats_ok, n_failures);
        if (n_failures == 0)
            $display("PASS positional_list_insert");
        else
            $display("FAIL positional_list_insert");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: bursts of requests with random gaps, changed on the falling edge
    // ------------------------------------------------------------------
    logic        in_took    = 1'b0;   // request beat moved at the last rising edge
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge clk)
    begin
        logic             nxt_valid;
        pli_pkg::pli_in_t nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (!rst_n)
            nxt_valid = 1'b0;
        else if (in_valid && !in_took)
            nxt_valid = 1'b1;             // keep offering the same beat
        else if (gap_left > 0)
        begin
            nxt_valid = 1'b0;
            gap_left--;
        end
        else if (pending_reqs.size() != 0)
        begin
            nxt_valid = 1'b1;
            nxt_data  = pending_reqs.pop_front();
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                // a quarter of bursts run straight into the next one
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
        end
        else
            nxt_valid = 1'b0;
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    // ------------------------------------------------------------------
    // receiver: ready pattern switches between modes, plus one long hold-off
    // while requests keep coming so that the block backs up to its input
    // ------------------------------------------------------------------
    int unsigned rx_mode      = 0;
    int unsigned rx_mode_left = 0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;

    always @(negedge clk)
    begin
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (!rst_n)
            nxt_ready = 1'b0;
        else if (hold_left > 0)
            hold_left--;
        else if (!hold_done && reqs_taken >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(16, 96);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       nxt_ready = 1'b1;                          // no stalls
                1:       nxt_ready = 1'($urandom_range(0, 1));
                2:       nxt_ready = ($urandom_range(0, 3) != 0);
                default: nxt_ready = ($urandom_range(0, 7) == 0);   // mostly stalled
            endcase
        end
        out_ready <= nxt_ready;
    end

    // ------------------------------------------------------------------
    // monitor: predict on each request beat, check each result beat against
    // the oldest prediction, and watch for a hang
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin
        pli_pkg::pli_out_t want;
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_insert(in_data);
                reqs_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing predicted: status %0d value %0d",
                           out_data.status, out_data.entry_value);
                    n_failures++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_data.status !== want.status)
                        $error("status: expected %0d, got %0d",
                               want.status, out_data.status);
                    if (out_data.direction !== want.direction)
                        $error("direction: expected %0d, got %0d",
                               want.direction, out_data.direction);
                    if (out_data.entry_value !== want.entry_value)
                        $error("entry_value: expected %0d, got %0d",
                               want.entry_value, out_data.entry_value);
                    if (out_data.last_of_run !== want.last_of_run)
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, out_data.last_of_run);
                    if (out_data !== want)
                        n_failures++;
                    else
                        n_beats_ok++;
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no beat moved for %0d cycles, %0d beats still predicted",
                         IDLE_LIMIT, expected_beats.size());
                $display("FAIL positional_list_insert");
                $finish;
            end
        end
    end

endmodule
